// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Expects signals named clk and arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/lstd_pkg.sv -----
// Shared types, constants and the CRC-16/CCITT byte update for the telegram deframer.
// No dependencies.
`default_nettype none

package lstd_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 4096;

	localparam int BYTE_W   = 8;
	localparam int RANGE_W  = 13;
	localparam int INDEX_W  = 11;
	localparam int STATUS_W = 3;

	localparam int HDR_ZEROS  = 6;
	localparam int POS_LEN_HI = 6;
	localparam int POS_LEN_LO = 7;
	localparam int POS_BODY   = 8;
	localparam int POS_TYPE_A = 20;
	localparam int POS_TYPE_B = 21;
	localparam int POS_DATA   = 24;
	localparam int MIN_FRAME  = 22;
	localparam int TRAILER    = 4;

	localparam logic [7:0] TYPE_SCAN      = 8'hBB;
	localparam logic [7:0] TYPE_IO        = 8'hAA;
	localparam logic [7:0] TYPE_REFLECTOR = 8'hCC;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_CRC       = 3'd1,
		ST_MISMATCH  = 3'd2,
		ST_IO        = 3'd3,
		ST_REFLECTOR = 3'd4,
		ST_UNKNOWN   = 3'd5,
		ST_LENGTH    = 3'd6
	} frame_status_t;

	typedef struct packed {
		logic init;
		logic step;
	} crc_ctl_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// CRC after the two zero bytes at offsets 4 and 5
	localparam logic [15:0] CRC_HDR = crc_byte(crc_byte(CRC_INIT, 8'h00), 8'h00);

endpackage

`default_nettype wire

// ----- src/lstd_byte_if.sv -----
// Byte input channel: valid/ready handshake with one received byte.
// Depends on lstd_pkg.
`default_nettype none

interface lstd_byte_if
	import lstd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- src/lstd_result_if.sv -----
// Result channel: valid/ready handshake with one range sample or frame status word.
// Depends on lstd_pkg.
`default_nettype none

interface lstd_result_if
	import lstd_pkg::*;
;
	logic                valid;
	logic                ready;
	logic                result_kind;
	logic [RANGE_W-1:0]  range_cm;
	logic [INDEX_W-1:0]  range_index;
	logic [STATUS_W-1:0] frame_status;
	logic [INDEX_W-1:0]  range_total;
	logic                frame_last;

	modport source (output valid, output result_kind, output range_cm, output range_index,
		output frame_status, output range_total, output frame_last, input ready);
	modport sink (input valid, input result_kind, input range_cm, input range_index,
		input frame_status, input range_total, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- src/lstd_crc.sv -----
// CRC-16/CCITT accumulator, one byte per cycle while ctl.step is set, with header preload.
// Depends on lstd_pkg.
`default_nettype none

module lstd_crc
	import lstd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire crc_ctl_t          ctl,
	input  wire logic [BYTE_W-1:0] data,
	output logic [15:0]            crc
);

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.init) begin
			crc_q <= CRC_HDR;
		end else if (ctl.step) begin
			crc_q <= crc_byte(crc_q, data);
		end
	end

	assign crc = crc_q;

endmodule

`default_nettype wire

// ----- src/laser_scan_telegram_deframer.sv -----
// Telegram deframer top level: header hunt, length check, CRC, range extraction.
// Depends on lstd_pkg, lstd_byte_if, lstd_result_if, lstd_crc.
//
//   channel  dir  handshake        word
//   rx       in   valid/ready      rx_byte
//   res      out  valid/ready      kind, range_cm, range_index, status, total, last
//
// One byte per cycle while rx.ready is high; each byte is parsed in the cycle it is accepted and its result,
// if any, lands in the output register at that edge.
// rx.ready is high whenever the output register is empty or being drained.
// A stall on res holds at most one word; rx stalls only while that word waits.
// Reset returns the parser to header hunt with the CRC at 0xFFFF.
`default_nettype none

module laser_scan_telegram_deframer
	import lstd_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lstd_byte_if.sink     rx,
	lstd_result_if.source res
);

	localparam int POS_W = $clog2(MAX_FRAME_BYTES);

	typedef enum logic {PH_HUNT, PH_FRAME} phase_t;

	phase_t               phase_q, phase_d;
	logic [2:0]           zero_run_q, zero_run_d;
	logic [POS_W-1:0]     pos_q, pos_d;
	logic [POS_W-1:0]     size_q, size_d;
	logic [7:0]           held_q, held_d;
	logic [7:0]           type_a_q, type_a_d;
	logic [7:0]           type_b_q, type_b_d;
	logic [INDEX_W-1:0]   count_q, count_d;

	logic                 out_valid_q, out_valid_d;
	logic                 out_kind_q, out_kind_d;
	logic [RANGE_W-1:0]   out_cm_q, out_cm_d;
	logic [INDEX_W-1:0]   out_idx_q, out_idx_d;
	logic [STATUS_W-1:0]  out_st_q, out_st_d;
	logic [INDEX_W-1:0]   out_tot_q, out_tot_d;
	logic                 out_last_q, out_last_d;

	logic                 take;
	logic [7:0]           b;
	logic [15:0]          word;
	logic [16:0]          size_full;
	logic                 len_bad;
	logic [POS_W:0]       pos_ext, size_ext;
	logic [15:0]          crc_val;
	crc_ctl_t             crc_ctl;
	frame_status_t        end_st;

	assign rx.ready = !out_valid_q || res.ready;
	assign take     = rx.valid && rx.ready;
	assign b        = rx.rx_byte;

	assign word      = {held_q, b};
	assign size_full = {word, 1'b0};
	assign len_bad   = (size_full < 17'(MIN_FRAME))
		|| ({1'b0, size_full} + 18'(TRAILER) > 18'(MAX_FRAME_BYTES));
	assign pos_ext   = {1'b0, pos_q};
	assign size_ext  = {1'b0, size_q};

	lstd_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (b),
		.crc    (crc_val)
	);

	always_comb begin
		if ({b, held_q} != crc_val)
			end_st = ST_CRC;
		else if (type_a_q != type_b_q)
			end_st = ST_MISMATCH;
		else if (type_a_q == TYPE_IO)
			end_st = ST_IO;
		else if (type_a_q == TYPE_SCAN)
			end_st = ST_OK;
		else if (type_a_q == TYPE_REFLECTOR)
			end_st = ST_REFLECTOR;
		else
			end_st = ST_UNKNOWN;
	end

	always_comb begin
		logic emit;
		emit       = 1'b0;
		phase_d    = phase_q;
		zero_run_d = zero_run_q;
		pos_d      = pos_q;
		size_d     = size_q;
		held_d     = held_q;
		type_a_d   = type_a_q;
		type_b_d   = type_b_q;
		count_d    = count_q;
		crc_ctl    = '0;
		out_kind_d = out_kind_q;
		out_cm_d   = out_cm_q;
		out_idx_d  = out_idx_q;
		out_st_d   = out_st_q;
		out_tot_d  = out_tot_q;
		out_last_d = out_last_q;

		if (take) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (b == 8'h00) begin
						if (zero_run_q == 3'(HDR_ZEROS - 1)) begin
							phase_d      = PH_FRAME;
							zero_run_d   = '0;
							pos_d        = POS_W'(POS_LEN_HI);
							held_d       = '0;
							type_a_d     = '0;
							type_b_d     = '0;
							count_d      = '0;
							crc_ctl.init = 1'b1;
						end else begin
							zero_run_d = zero_run_q + 3'd1;
						end
					end else begin
						zero_run_d = '0;
					end
				end
				PH_FRAME: begin
					if (pos_q == POS_W'(POS_LEN_HI)) begin
						held_d       = b;
						crc_ctl.step = 1'b1;
						pos_d        = POS_W'(POS_LEN_LO);
					end else if (pos_q == POS_W'(POS_LEN_LO)) begin
						crc_ctl.step = 1'b1;
						if (len_bad) begin
							emit       = 1'b1;
							out_kind_d = 1'b1;
							out_cm_d   = '0;
							out_idx_d  = '0;
							out_st_d   = ST_LENGTH;
							out_tot_d  = '0;
							out_last_d = 1'b1;
							phase_d    = PH_HUNT;
							zero_run_d = '0;
							pos_d      = '0;
						end else begin
							size_d = size_full[POS_W-1:0];
							pos_d  = POS_W'(POS_BODY);
						end
					end else if (pos_ext <= size_ext + (POS_W+1)'(1)) begin
						crc_ctl.step = 1'b1;
						if (pos_q == POS_W'(POS_TYPE_A)) begin
							type_a_d = b;
						end else if (pos_q == POS_W'(POS_TYPE_B)) begin
							type_b_d = b;
						end else if (pos_q >= POS_W'(POS_DATA)) begin
							if (!pos_q[0]) begin
								held_d = b;
							end else if (type_a_q == TYPE_SCAN && type_b_q == TYPE_SCAN) begin
								emit       = 1'b1;
								out_kind_d = 1'b0;
								out_cm_d   = {b[RANGE_W-9:0], held_q};
								out_idx_d  = count_q;
								out_st_d   = '0;
								out_tot_d  = '0;
								out_last_d = 1'b0;
								count_d    = count_q + INDEX_W'(1);
							end
						end
						pos_d = pos_q + POS_W'(1);
					end else if (pos_ext == size_ext + (POS_W+1)'(2)) begin
						held_d = b;
						pos_d  = pos_q + POS_W'(1);
					end else begin
						emit       = 1'b1;
						out_kind_d = 1'b1;
						out_cm_d   = '0;
						out_idx_d  = '0;
						out_st_d   = end_st;
						out_tot_d  = count_q;
						out_last_d = 1'b1;
						phase_d    = PH_HUNT;
						zero_run_d = '0;
						pos_d      = '0;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end

		if (take && emit)
			out_valid_d = 1'b1;
		else if (res.ready)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			zero_run_q  <= '0;
			pos_q       <= '0;
			size_q      <= '0;
			held_q      <= '0;
			type_a_q    <= '0;
			type_b_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= 1'b0;
			out_cm_q    <= '0;
			out_idx_q   <= '0;
			out_st_q    <= '0;
			out_tot_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			zero_run_q  <= zero_run_d;
			pos_q       <= pos_d;
			size_q      <= size_d;
			held_q      <= held_d;
			type_a_q    <= type_a_d;
			type_b_q    <= type_b_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
			out_kind_q  <= out_kind_d;
			out_cm_q    <= out_cm_d;
			out_idx_q   <= out_idx_d;
			out_st_q    <= out_st_d;
			out_tot_q   <= out_tot_d;
			out_last_q  <= out_last_d;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.result_kind  = out_kind_q;
	assign res.range_cm     = out_cm_q;
	assign res.range_index  = out_idx_q;
	assign res.frame_status = out_st_q;
	assign res.range_total  = out_tot_q;
	assign res.frame_last   = out_last_q;

endmodule

`default_nettype wire

// ----- src/lstd_checker.sv -----
// Port-level checks on the deframer result channel, bound to the top level.
// Depends on lstd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lstd_checker
	import lstd_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire logic                result_kind,
	input wire logic [RANGE_W-1:0]  range_cm,
	input wire logic [INDEX_W-1:0]  range_index,
	input wire logic [STATUS_W-1:0] frame_status,
	input wire logic [INDEX_W-1:0]  range_total,
	input wire logic                frame_last
);

	logic [INDEX_W-1:0]                      exp_idx_q;
	logic                                    res_take;
	logic [RANGE_W+2*INDEX_W+STATUS_W+2:0]   res_word;

	assign res_take = res_valid && res_ready;
	assign res_word = {result_kind, range_cm, range_index, frame_status, range_total, frame_last};

	// samples expected since the last status word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (res_take) begin
			if (result_kind)
				exp_idx_q <= '0;
			else
				exp_idx_q <= exp_idx_q + INDEX_W'(1);
		end
	end

	`ASSERT_NXT(a_valid_holds, res_valid && !res_ready, res_valid)
	`ASSERT_NXT(a_word_holds, res_valid && !res_ready, $stable(res_word))
	`ASSERT_IMP(a_index_seq, res_take && !result_kind, range_index == exp_idx_q && !frame_last)
	`ASSERT_IMP(a_total_match, res_take && result_kind, frame_last && range_total == exp_idx_q)
	`ASSERT_IMP(a_length_total, res_take && result_kind && frame_status == ST_LENGTH, range_total == '0)

endmodule

bind laser_scan_telegram_deframer lstd_checker u_lstd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.result_kind  (res.result_kind),
	.range_cm     (res.range_cm),
	.range_index  (res.range_index),
	.frame_status (res.frame_status),
	.range_total  (res.range_total),
	.frame_last   (res.frame_last)
);

`default_nettype wire

// ----- tb/lstd_deframer_checker.sv -----
// Watches both channels of the telegram deframer, predicts each result word and compares it.
// Depends on lstd_pkg, lstd_byte_if and lstd_result_if.
`default_nettype none

module lstd_deframer_checker
	import lstd_pkg::*;
#(
	parameter int MAX_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lstd_byte_if      rx,
	lstd_result_if    res,
	output int        fails,
	output int        outstanding,
	output int        checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                kind;
		logic [RANGE_W-1:0]  cm;
		logic [INDEX_W-1:0]  idx;
		frame_status_t       status;
		logic [INDEX_W-1:0]  total;
		logic                last;
	} deframe_word_t;

	logic               in_frame;
	logic [2:0]         zeros_seen;
	logic [11:0]        pos;
	logic [16:0]        size;
	logic [15:0]        crc;
	logic [7:0]         held;
	logic [7:0]         type_a;
	logic [7:0]         type_b;
	logic [INDEX_W-1:0] n_samples;

	deframe_word_t expected_words[$];
	deframe_word_t want;
	int            err_cnt;
	int            n_checked;

	// bit-serial CCITT update, MSB first
	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] r;
		logic        fb;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			fb = r[15] ^ d[i];
			r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

	function automatic void finish_frame(input frame_status_t st, input logic [INDEX_W-1:0] total);
		deframe_word_t w;
		w.kind = 1'b1;
		w.cm = '0;
		w.idx = '0;
		w.status = st;
		w.total = total;
		w.last = 1'b1;
		expected_words.push_back(w);
		in_frame = 1'b0;
		zeros_seen = '0;
		pos = '0;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		deframe_word_t w;
		frame_status_t st;
		if (!in_frame) begin
			if (b != 8'h00) begin
				zeros_seen = '0;
			end else if (zeros_seen == HDR_ZEROS - 1) begin
				in_frame = 1'b1;
				zeros_seen = '0;
				pos = POS_LEN_HI;
				size = '0;
				crc = crc_next(crc_next(CRC_INIT, 8'h00), 8'h00);
				held = '0;
				type_a = '0;
				type_b = '0;
				n_samples = '0;
			end else begin
				zeros_seen = zeros_seen + 1'b1;
			end
		end else if (pos == POS_LEN_HI) begin
			held = b;
			crc = crc_next(crc, b);
			pos = POS_LEN_LO;
		end else if (pos == POS_LEN_LO) begin
			size = {held, b, 1'b0};
			crc = crc_next(crc, b);
			if (size < MIN_FRAME || size + TRAILER > MAX_BYTES)
				finish_frame(ST_LENGTH, '0);
			else
				pos = POS_BODY;
		end else if (pos <= size + 1) begin
			crc = crc_next(crc, b);
			if (pos == POS_TYPE_A) begin
				type_a = b;
			end else if (pos == POS_TYPE_B) begin
				type_b = b;
			end else if (pos >= POS_DATA) begin
				if (!pos[0]) begin
					held = b;
				end else if (type_a == TYPE_SCAN && type_b == TYPE_SCAN) begin
					w.kind = 1'b0;
					w.cm = {b[4:0], held};
					w.idx = n_samples;
					w.status = ST_OK;
					w.total = '0;
					w.last = 1'b0;
					expected_words.push_back(w);
					n_samples = n_samples + 1'b1;
				end
			end
			pos = pos + 1'b1;
		end else if (pos == size + 2) begin
			held = b;
			pos = pos + 1'b1;
		end else begin
			if ({b, held} != crc)
				st = ST_CRC;
			else if (type_a != type_b)
				st = ST_MISMATCH;
			else if (type_a == TYPE_IO)
				st = ST_IO;
			else if (type_a == TYPE_SCAN)
				st = ST_OK;
			else if (type_a == TYPE_REFLECTOR)
				st = ST_REFLECTOR;
			else
				st = ST_UNKNOWN;
			finish_frame(st, n_samples);
		end
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_val,
		input logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame = 1'b0;
			zeros_seen = '0;
			pos = '0;
			size = '0;
			crc = CRC_INIT;
			held = '0;
			type_a = '0;
			type_b = '0;
			n_samples = '0;
			expected_words.delete();
			err_cnt = 0;
			n_checked = 0;
			fails <= 0;
			outstanding <= 0;
			checked <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected: kind %0d status %0d",
						res.result_kind, res.frame_status);
					err_cnt++;
				end else begin
					want = expected_words.pop_front();
					check_field("result_kind", want.kind, res.result_kind);
					check_field("range_cm", want.cm, res.range_cm);
					check_field("range_index", want.idx, res.range_index);
					check_field("frame_status", want.status, res.frame_status);
					check_field("range_total", want.total, res.range_total);
					check_field("frame_last", want.last, res.frame_last);
					n_checked++;
				end
			end
			if (rx.valid && rx.ready)
				deframe_byte(rx.rx_byte);
			fails <= err_cnt;
			outstanding <= expected_words.size();
			checked <= n_checked;
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Top of the telegram deframer testbench: clock, reset, telegram stimulus and verdict.
// Depends on lstd_pkg, both channel interfaces, the deframer and lstd_deframer_checker.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lstd_pkg::*;

	logic clk;
	logic arst_n;
	int   fails;
	int   outstanding;
	int   checked;

	lstd_byte_if   rx ();
	lstd_result_if res ();

	laser_scan_telegram_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.res(res)
	);

	lstd_deframer_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.res(res),
		.fails(fails),
		.outstanding(outstanding),
		.checked(checked)
	);

	logic [7:0]  tele[$];
	logic [15:0] corner_word [4] = '{16'h0000, 16'hFFFF, 16'h1FFF, 16'hE000};
	int          src_mode;
	int          snk_mode;
	int          hold = 0;
	int          n_sent = 0;
	int          n_tele = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int idle_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(6, 30);
	endfunction

	always @(posedge clk) begin
		if (hold > 0) begin
			hold <= hold - 1;
			res.ready <= 1'b0;
		end else if (snk_mode != 0 && $urandom_range(0, 99) < (snk_mode == 1 ? 8 : 30)) begin
			hold <= idle_len() - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	// header, length, body with type bytes, checksum; stops after the length on a bad size
	function automatic void build_telegram(input logic [15:0] len, input logic [7:0] t20,
		input logic [7:0] t21, input bit bad_crc, input bit corner_words);
		logic [16:0] size;
		logic [15:0] crc;
		logic [15:0] w;
		logic [7:0]  b;
		tele.delete();
		repeat (HDR_ZEROS) tele.push_back(8'h00);
		tele.push_back(len[15:8]);
		tele.push_back(len[7:0]);
		size = {len, 1'b0};
		if (size < MIN_FRAME || size + TRAILER > MAX_FRAME_BYTES_DEF)
			return;
		for (int p = POS_BODY; p <= size + 1; p++) begin
			if (p == POS_TYPE_A) begin
				b = t20;
			end else if (p == POS_TYPE_B) begin
				b = t21;
			end else if (p >= POS_DATA && corner_words) begin
				w = corner_word[((p - POS_DATA) / 2) % 4];
				b = p[0] ? w[15:8] : w[7:0];
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			tele.push_back(b);
		end
		crc = CRC_HDR;
		for (int i = POS_LEN_HI; i < tele.size(); i++)
			crc = crc_byte(crc, tele[i]);
		if (bad_crc)
			crc = crc ^ (16'h0001 << $urandom_range(0, 15));
		tele.push_back(crc[7:0]);
		tele.push_back(crc[15:8]);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (src_mode != 0 && $urandom_range(0, 99) < (src_mode == 1 ? 8 : 30))
			gap = idle_len();
		if (gap != 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		n_sent++;
	endtask

	task automatic send_telegram(input int count);
		for (int i = 0; i < count && i < tele.size(); i++)
			send_byte(tele[i]);
		n_tele++;
	endtask

	task automatic send_noise(input int count, input bit end_nonzero);
		for (int i = 0; i < count; i++)
			if (end_nonzero && i == count - 1)
				send_byte(8'($urandom_range(1, 255)));
			else
				send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		rx.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic send_one(input logic [15:0] len, input logic [7:0] t20, input logic [7:0] t21,
		input bit bad_crc, input bit corner_words);
		build_telegram(len, t20, t21, bad_crc, corner_words);
		send_telegram(tele.size());
	endtask

	initial begin
		int         r;
		logic [7:0] t20;
		logic [7:0] t21;
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		res.ready = 1'b0;
		src_mode = 0;
		snk_mode = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_one(16'd11, TYPE_SCAN, TYPE_SCAN, 1'b0, 1'b0);
		send_one(16'd15, TYPE_SCAN, TYPE_SCAN, 1'b0, 1'b1);
		send_one(16'd12, TYPE_IO, TYPE_IO, 1'b0, 1'b0);
		send_one(16'd12, TYPE_REFLECTOR, TYPE_REFLECTOR, 1'b0, 1'b0);
		send_one(16'd12, 8'h00, 8'h00, 1'b0, 1'b0);
		send_one(16'd13, TYPE_SCAN, TYPE_IO, 1'b0, 1'b1);
		send_one(16'd13, TYPE_SCAN, TYPE_SCAN, 1'b1, 1'b1);
		send_one(16'd12, TYPE_IO, TYPE_SCAN, 1'b1, 1'b0);
		send_one(16'd10, TYPE_SCAN, TYPE_SCAN, 1'b0, 1'b0);
		send_one(16'd0, TYPE_SCAN, TYPE_SCAN, 1'b0, 1'b0);
		send_one(16'hFFFF, TYPE_SCAN, TYPE_SCAN, 1'b0, 1'b0);
		send_one(16'd2047, TYPE_SCAN, TYPE_SCAN, 1'b0, 1'b0);
		// long zero run: the first two extra zeros land in the length word and give a length error
		repeat (10) send_byte(8'h00);
		send_byte(8'h5A);
		drain();
		src_mode = 1;
		snk_mode = 2;
		send_one(16'd120, TYPE_SCAN, TYPE_SCAN, 1'b0, 1'b0);
		drain();

		while (n_sent < 950) begin
			src_mode = $urandom_range(0, 2);
			snk_mode = $urandom_range(0, 2);
			r = $urandom_range(0, 99);
			if (r < 58) begin
				send_one(16'(11 + $urandom_range(0, 20)), TYPE_SCAN, TYPE_SCAN, 1'b0,
					$urandom_range(0, 5) == 0);
			end else if (r < 66) begin
				send_one(16'(11 + $urandom_range(0, 20)), TYPE_SCAN, TYPE_SCAN, 1'b1, 1'b0);
			end else if (r < 78) begin
				case ($urandom_range(0, 4))
					0: begin t20 = TYPE_IO; t21 = TYPE_IO; end
					1: begin t20 = TYPE_REFLECTOR; t21 = TYPE_REFLECTOR; end
					2: begin t20 = 8'($urandom_range(0, 255)); t21 = t20; end
					3: begin t20 = 8'($urandom_range(0, 255)); t21 = 8'($urandom_range(0, 255)); end
					default: begin t20 = TYPE_SCAN; t21 = 8'($urandom_range(0, 255)); end
				endcase
				send_one(16'(11 + $urandom_range(0, 12)), t20, t21, $urandom_range(0, 6) == 0,
					1'b0);
			end else if (r < 84) begin
				if ($urandom_range(0, 1) != 0)
					send_one(16'($urandom_range(0, 10)), TYPE_SCAN, TYPE_SCAN, 1'b0, 1'b0);
				else
					send_one(16'($urandom_range(2047, 65535)), TYPE_SCAN, TYPE_SCAN, 1'b0,
						1'b0);
			end else if (r < 93) begin
				send_noise($urandom_range(1, 12), $urandom_range(0, 4) != 0);
			end else begin
				build_telegram(16'(11 + $urandom_range(0, 8)), TYPE_SCAN, TYPE_SCAN, 1'b0, 1'b0);
				send_telegram($urandom_range(1, tele.size() - 1));
			end
			if ($urandom_range(0, 11) == 0)
				drain();
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes in %0d telegrams plus noise; %0d result words checked.",
			n_sent, n_tele, checked);
		$display("Covered scan, I/O, reflector, unknown and mismatched types, CRC and length errors.");
		if (fails == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
